### design/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;

  localparam int MaxCodeLen = 32;
  localparam int CodeW      = 32;
  localparam int LenW       = 6;
  localparam int SymW       = 8;
  localparam int TableDepth = 256;
  localparam int ByteW      = 8;
  localparam int PadW       = 3;
  localparam int PendW      = ByteW - 1;
  localparam int AccW       = PendW + CodeW;
  localparam int TotW       = $clog2(AccW + 1);
  localparam int EntryW     = LenW + CodeW;
  localparam int QueueDepth = 4;

  localparam int LenLimitInt = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
  localparam logic [LenW-1:0] LenLimit = LenW'(LenLimitInt);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_ENCODE,
    CMD_MISS,
    CMD_FLUSH
  } cmd_e;

  typedef struct packed {
    cmd_e            kind;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic             byte_valid;
    logic [PadW-1:0]  pad_count;
    logic             missing_code;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

### design/hcbp_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module hcbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/hcbp_front.sv
// Front end: table loads, code lookup and command classification.
`default_nettype none
module hcbp_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output      logic                        full_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [hcbp_pkg::SymW-1:0]   symbol_i,
  input  wire logic [hcbp_pkg::CodeW-1:0]  code_word_i,
  input  wire logic [hcbp_pkg::LenW-1:0]   code_length_i,
  output      logic                        q_push_o,
  output      hcbp_pkg::cmd_t              q_cmd_o,
  input  wire logic                        q_full_i
);

  logic [hcbp_pkg::TableDepth-1:0] entry_valid_q;
  logic                            s1_valid_q;
  logic                            s1_flush_q;
  logic                            s1_hit_q;
  logic                            advance;
  logic                            accept;
  logic                            is_load, is_encode, is_flush;
  logic [hcbp_pkg::LenW-1:0]       len_sat;
  logic [hcbp_pkg::CodeW-1:0]      code_mask;
  logic [hcbp_pkg::EntryW-1:0]     entry_wdata;
  logic [hcbp_pkg::EntryW-1:0]     entry_rdata;

  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    unique case (hcbp_pkg::op_e'(operation_i))
      hcbp_pkg::OP_LOAD:   is_load   = 1'b1;
      hcbp_pkg::OP_ENCODE: is_encode = 1'b1;
      hcbp_pkg::OP_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  assign advance = !s1_valid_q || !q_full_i;
  assign full_o  = !advance;
  assign accept  = push_i && advance;

  assign len_sat = (code_length_i > hcbp_pkg::LenLimit) ? hcbp_pkg::LenLimit : code_length_i;
  assign code_mask = hcbp_pkg::CodeW'((33'd1 << len_sat) - 33'd1);
  assign entry_wdata = {len_sat, code_word_i & code_mask};

  hcbp_ram #(
    .Width(hcbp_pkg::EntryW),
    .Depth(hcbp_pkg::TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (accept && is_load),
    .re_i   (accept && is_encode),
    .addr_i (symbol_i),
    .wdata_i(entry_wdata),
    .rdata_o(entry_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      s1_valid_q    <= 1'b0;
    end else begin
      if (accept && is_load) begin
        entry_valid_q[symbol_i] <= 1'b1;
      end
      if (advance) begin
        s1_valid_q <= accept && (is_encode || is_flush);
      end
    end
  end

  // hold the lookup stage while the queue is full
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flush_q <= is_flush;
      s1_hit_q   <= entry_valid_q[symbol_i];
    end
  end

  always_comb begin
    q_push_o     = s1_valid_q && !q_full_i;
    q_cmd_o.code = entry_rdata[hcbp_pkg::CodeW-1:0];
    q_cmd_o.len  = entry_rdata[hcbp_pkg::EntryW-1:hcbp_pkg::CodeW];
    priority if (s1_flush_q) begin
      q_cmd_o.kind = hcbp_pkg::CMD_FLUSH;
    end else if (s1_hit_q) begin
      q_cmd_o.kind = hcbp_pkg::CMD_ENCODE;
    end else begin
      q_cmd_o.kind = hcbp_pkg::CMD_MISS;
    end
  end

endmodule
`default_nettype wire

### design/hcbp_queue.sv
// Command queue between the front end and the packer.
`default_nettype none
module hcbp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hcbp_pkg::cmd_t cmd_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      hcbp_pkg::cmd_t cmd_o,
  output      logic           empty_o
);

  localparam int PtrW = $clog2(hcbp_pkg::QueueDepth);

  hcbp_pkg::cmd_t    slot_q [hcbp_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(hcbp_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

### design/hcbp_back.sv
// Packer: bit accumulator, byte emission and result register.
`default_nettype none
module hcbp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hcbp_pkg::cmd_t cmd_i,
  input  wire logic           q_empty_i,
  output      logic           q_pop_o,
  output      hcbp_pkg::res_t res_o,
  output      logic           empty_o,
  input  wire logic           pop_i
);

  localparam int AccW  = hcbp_pkg::AccW;
  localparam int TotW  = hcbp_pkg::TotW;
  localparam int ByteW = hcbp_pkg::ByteW;
  localparam int CntW  = $clog2(ByteW);
  localparam logic [TotW-1:0] ByteBits = TotW'(ByteW);

  logic [AccW-1:0]         acc_q, acc_d;
  logic [TotW-1:0]         tot_q, tot_d;
  logic                    busy_q, busy_d;
  logic                    out_vld_q, out_vld_d;
  hcbp_pkg::res_t          out_q, out_d;
  logic                    out_rdy, emit, idle_next;
  logic [TotW-1:0]         tot_m8, cur_tot;
  logic [hcbp_pkg::PendW-1:0] pend;
  logic [CntW-1:0]         cnt;
  logic [CntW:0]           pad;

  always_comb begin
    out_rdy   = !out_vld_q || pop_i;
    emit      = busy_q && out_rdy;
    tot_m8    = tot_q - ByteBits;
    cur_tot   = emit ? tot_m8 : tot_q;
    idle_next = !busy_q || (emit && (tot_m8 < ByteBits));
    pend      = acc_q[hcbp_pkg::PendW-1:0]
              & hcbp_pkg::PendW'((ByteW'(1) << cur_tot[CntW-1:0]) - ByteW'(1));
    cnt       = tot_q[CntW-1:0];
    pad       = (CntW+1)'(ByteW) - (CntW+1)'(cnt);

    q_pop_o = 1'b0;
    if (!q_empty_i) begin
      unique case (cmd_i.kind)
        hcbp_pkg::CMD_ENCODE: q_pop_o = idle_next;
        hcbp_pkg::CMD_MISS,
        hcbp_pkg::CMD_FLUSH:  q_pop_o = !busy_q && out_rdy;
        default:              q_pop_o = 1'b0;
      endcase
    end
  end

  always_comb begin
    acc_d     = acc_q;
    tot_d     = cur_tot;
    busy_d    = emit ? (tot_m8 >= ByteBits) : busy_q;
    out_vld_d = out_vld_q && !pop_i;
    out_d     = out_q;

    if (emit) begin
      out_vld_d          = 1'b1;
      out_d.byte_out     = ByteW'(acc_q >> tot_m8);
      out_d.byte_valid   = 1'b1;
      out_d.pad_count    = '0;
      out_d.missing_code = 1'b0;
      out_d.last         = (tot_m8 < ByteBits);
    end

    if (q_pop_o) begin
      unique case (cmd_i.kind)
        hcbp_pkg::CMD_ENCODE: begin
          acc_d  = (AccW'(pend) << cmd_i.len) | AccW'(cmd_i.code);
          tot_d  = TotW'(cur_tot[CntW-1:0]) + TotW'(cmd_i.len);
          busy_d = (tot_d >= ByteBits);
        end
        hcbp_pkg::CMD_MISS: begin
          out_vld_d          = 1'b1;
          out_d.byte_out     = '0;
          out_d.byte_valid   = 1'b0;
          out_d.pad_count    = '0;
          out_d.missing_code = 1'b1;
          out_d.last         = 1'b1;
        end
        hcbp_pkg::CMD_FLUSH: begin
          out_vld_d          = 1'b1;
          out_d.missing_code = 1'b0;
          out_d.last         = 1'b1;
          if (cnt == '0) begin
            out_d.byte_out   = '0;
            out_d.byte_valid = 1'b0;
            out_d.pad_count  = '0;
          end else begin
            // bits above the pending count shift out past the byte
            out_d.byte_out   = ByteW'(acc_q[ByteW-1:0] << pad);
            out_d.byte_valid = 1'b1;
            out_d.pad_count  = hcbp_pkg::PadW'(pad);
          end
          acc_d = '0;
          tot_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      tot_q     <= '0;
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      tot_q     <= tot_d;
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o   = out_q;
  assign empty_o = !out_vld_q;

endmodule
`default_nettype wire

### design/huffman_code_bit_packer_core.sv
// Top level of the table-driven Huffman code bit packer.
//
//   channel   handshake          payload
//   input     push_i / full_o    operation_i, symbol_i, code_word_i, code_length_i
//   result    empty_o / pop_i    byte_out_o, byte_valid_o, pad_count_o,
//                                missing_code_o, last_o
//
// The front end takes one item per cycle while full_o is low; lookup in the
// 256-entry code table is registered, then a 4-entry command queue feeds the packer.
// The packer emits each byte as the result register frees, up to 4 per encode;
// it pops the next encode as its last byte goes, and a miss or flush when idle.
// Reset clears the valid marks and the accumulator at once; table contents
// stay as they were and are only read behind a set valid mark.
// A stalled result register stalls the packer, then the queue, then full_o.
`default_nettype none
module huffman_code_bit_packer_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output      logic                        full_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [hcbp_pkg::SymW-1:0]   symbol_i,
  input  wire logic [hcbp_pkg::CodeW-1:0]  code_word_i,
  input  wire logic [hcbp_pkg::LenW-1:0]   code_length_i,
  output      logic                        empty_o,
  input  wire logic                        pop_i,
  output      logic [hcbp_pkg::ByteW-1:0]  byte_out_o,
  output      logic                        byte_valid_o,
  output      logic [hcbp_pkg::PadW-1:0]   pad_count_o,
  output      logic                        missing_code_o,
  output      logic                        last_o
);

  logic           q_push, q_full, q_pop, q_empty;
  hcbp_pkg::cmd_t q_in, q_out;
  hcbp_pkg::res_t res;

  hcbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .operation_i  (operation_i),
    .symbol_i     (symbol_i),
    .code_word_i  (code_word_i),
    .code_length_i(code_length_i),
    .q_push_o     (q_push),
    .q_cmd_o      (q_in),
    .q_full_i     (q_full)
  );

  hcbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .cmd_o  (q_out),
    .empty_o(q_empty)
  );

  hcbp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (q_out),
    .q_empty_i(q_empty),
    .q_pop_o  (q_pop),
    .res_o    (res),
    .empty_o  (empty_o),
    .pop_i    (pop_i)
  );

  assign byte_out_o     = res.byte_out;
  assign byte_valid_o   = res.byte_valid;
  assign pad_count_o    = res.pad_count;
  assign missing_code_o = res.missing_code;
  assign last_o         = res.last;

`ifndef SYNTHESIS
  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("command queue overflow");

  a_miss_has_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && missing_code_o) |-> (!byte_valid_o && last_o))
    else $error("miss result carries a byte");

  a_pad_only_on_flush_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pad_count_o != '0) |-> (byte_valid_o && last_o && !missing_code_o))
    else $error("pad count outside a flush byte");

  a_result_holds_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(byte_out_o) && $stable(last_o)))
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire
